FILE: rtl/opq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// opq_pkg
// Shared types and codes for the ordered process queue.
// ---------------------------------------------------------------------------
package opq_pkg;

    // One held entry: pid and every ordering key, so a later change of
    // order mode still compares against the stored keys.
    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [31:0] rdy;
        logic [31:0] iod;
        logic [31:0] arr;
    } opq_entry_t;

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_DUP   = 3'd1;
    localparam logic [2:0] STAT_STATE = 3'd2;
    localparam logic [2:0] STAT_FULL  = 3'd3;
    localparam logic [2:0] STAT_EMPTY = 3'd4;

    // Queue kinds (state check)
    localparam logic [1:0] KIND_READY   = 2'd0;
    localparam logic [1:0] KIND_FUTURE  = 2'd1;
    localparam logic [1:0] KIND_BLOCKED = 2'd2;

    // Order modes; the remaining codes act as fifo
    localparam logic [2:0] ORD_READY = 3'd1;
    localparam logic [2:0] ORD_PRIO  = 3'd2;
    localparam logic [2:0] ORD_IO    = 3'd3;
    localparam logic [2:0] ORD_ARR   = 3'd4;

    // Process states
    localparam logic [2:0] PS_NEW      = 3'd0;
    localparam logic [2:0] PS_BLOCKED  = 3'd3;
    localparam logic [2:0] PS_FINISHED = 3'd4;

    // Configuration register indexes
    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_POP_RD,
        ST_POP_WR
    } opq_state_t;

endpackage
`default_nettype wire

FILE: rtl/opq_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// opq_mem
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module opq_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire opq_pkg::opq_entry_t       wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output opq_pkg::opq_entry_t            rdata
);

    opq_pkg::opq_entry_t mem [DEPTH];
    opq_pkg::opq_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/opq_cmp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// opq_cmp
// Shared compare unit: pid match and strict precedence under the order mode.
// ---------------------------------------------------------------------------
module opq_cmp (
    input  wire logic [2:0]           mode,
    input  wire opq_pkg::opq_entry_t  cand,
    input  wire opq_pkg::opq_entry_t  held,
    output logic                      pid_eq,
    output logic                      precedes
);

    logic pid_lt;

    assign pid_eq = (cand.pid == held.pid);
    assign pid_lt = (cand.pid < held.pid);

    always_comb
    begin
        case (mode)
            opq_pkg::ORD_READY:
                precedes = (cand.rdy != held.rdy) ? (cand.rdy < held.rdy) : pid_lt;
            opq_pkg::ORD_PRIO:
            begin
                if (cand.prio != held.prio)
                    precedes = (cand.prio < held.prio);
                else if (cand.rdy != held.rdy)
                    precedes = (cand.rdy < held.rdy);
                else
                    precedes = pid_lt;
            end
            opq_pkg::ORD_IO:
                precedes = (cand.iod != held.iod) ? (cand.iod < held.iod) : pid_lt;
            opq_pkg::ORD_ARR:
                precedes = (cand.arr != held.arr) ? (cand.arr < held.arr) : pid_lt;
            default:
                precedes = 1'b0;  // fifo: new entry goes to the tail
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/ordered_process_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ordered_process_queue
// Bounded, sorted queue of process ids with insert, pop and query commands.
// ---------------------------------------------------------------------------
// Steps: insert and query read and compare every held entry, then decide; an
//   accepted insert moves each entry from the insert place toward the tail, then
//   writes the new one. Pop moves each remaining entry toward the head.
// One command at a time; each held entry is read from the entry memory, then
// compared or moved. A new command is taken only once the last one is done.
// Reset clears the count, sequencer state, configuration and done, not the
// working registers or the entry memory; done cannot stall.
module ordered_process_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [2:0]  cfg_wdata,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] proc_id,
    input  wire logic [2:0]  proc_state,
    input  wire logic [7:0]  prio_level,
    input  wire logic [31:0] ready_time,
    input  wire logic [31:0] io_done_time,
    input  wire logic [31:0] arrive_time,
    // result side
    output logic             done,
    output logic [2:0]       status,
    output logic [15:0]      popped_id,
    output logic             found,
    output logic [15:0]      head_id,
    output logic             is_empty,
    output logic [4:0]       entry_total
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer and working registers
    opq_pkg::opq_state_t state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    opq_pkg::opq_entry_t item_reg, item_next;
    logic [2:0]          pstate_reg, pstate_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                posf_reg, posf_next;
    logic                dup_reg, dup_next;

    // Architectural state
    logic [CW-1:0]       fill_reg, fill_next;
    logic [15:0]         head_reg, head_next;
    logic [1:0]          kind_reg, kind_next;
    logic [2:0]          mode_reg, mode_next;

    // Result registers
    logic                done_reg, done_next;
    logic [2:0]          status_reg, status_next;
    logic [15:0]         popped_reg, popped_next;
    logic                found_reg, found_next;

    // Memory and compare unit hookup
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    opq_pkg::opq_entry_t mem_wdata;
    logic [AW-1:0]       mem_raddr;
    opq_pkg::opq_entry_t mem_rdata;
    logic                cmp_eq;
    logic                cmp_prec;
    logic                state_ok;

    opq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    opq_cmp u_cmp (
        .mode     (mode_reg),
        .cand     (item_reg),
        .held     (mem_rdata),
        .pid_eq   (cmp_eq),
        .precedes (cmp_prec)
    );

    // Does the latched process state suit this queue kind?
    always_comb
    begin
        case (kind_reg)
            opq_pkg::KIND_READY:
                state_ok = !(pstate_reg == opq_pkg::PS_NEW ||
                             pstate_reg == opq_pkg::PS_BLOCKED ||
                             pstate_reg == opq_pkg::PS_FINISHED);
            opq_pkg::KIND_FUTURE:  state_ok = (pstate_reg == opq_pkg::PS_NEW);
            opq_pkg::KIND_BLOCKED: state_ok = (pstate_reg == opq_pkg::PS_BLOCKED);
            default:               state_ok = 1'b1;
        endcase
    end

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        item_next   = item_reg;
        pstate_next = pstate_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        posf_next   = posf_reg;
        dup_next    = dup_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        kind_next   = kind_reg;
        mode_next   = mode_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popped_next = popped_reg;
        found_next  = found_reg;

        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg[AW-1:0];

        // Configuration is to be written only while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_idx)
                opq_pkg::CFG_KIND: kind_next = cfg_wdata[1:0];
                opq_pkg::CFG_MODE: mode_next = cfg_wdata;
                default:           mode_next = mode_reg;
            endcase
        end

        unique case (state_reg)
            opq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // Latch the command and clear the scan flags
                    op_next     = opcode;
                    item_next   = '{pid: proc_id, prio: prio_level, rdy: ready_time,
                                    iod: io_done_time, arr: arrive_time};
                    pstate_next = proc_state;
                    idx_next    = '0;
                    pos_next    = fill_reg;
                    posf_next   = 1'b0;
                    dup_next    = 1'b0;
                    popped_next = '0;
                    found_next  = 1'b0;
                    status_next = opq_pkg::STAT_OK;
                    unique case (opcode) inside
                        opq_pkg::OP_INSERT, opq_pkg::OP_QUERY:
                        begin
                            state_next = (fill_reg == '0) ? opq_pkg::ST_DECIDE
                                                          : opq_pkg::ST_SCAN_RD;
                        end
                        opq_pkg::OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = opq_pkg::STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                popped_next = head_reg;
                                if (fill_reg == CW'(1))
                                begin
                                    fill_next = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    idx_next   = CW'(1);
                                    state_next = opq_pkg::ST_POP_RD;
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;  // unused opcode: no change
                        end
                    endcase
                end
            end

            opq_pkg::ST_SCAN_RD:
            begin
                state_next = opq_pkg::ST_SCAN_CMP;
            end

            opq_pkg::ST_SCAN_CMP:
            begin
                // Note duplicates and the first entry the new one precedes
                if (cmp_eq)
                    dup_next = 1'b1;
                if (cmp_prec && !posf_reg)
                begin
                    pos_next  = idx_reg;
                    posf_next = 1'b1;
                end
                if (idx_reg == fill_reg - CW'(1))
                    state_next = opq_pkg::ST_DECIDE;
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = opq_pkg::ST_SCAN_RD;
                end
            end

            opq_pkg::ST_DECIDE:
            begin
                state_next = opq_pkg::ST_IDLE;
                if (op_reg == opq_pkg::OP_QUERY)
                begin
                    found_next = dup_reg;
                    done_next  = 1'b1;
                end
                else if (dup_reg)
                begin
                    status_next = opq_pkg::STAT_DUP;
                    done_next   = 1'b1;
                end
                else if (!state_ok)
                begin
                    status_next = opq_pkg::STAT_STATE;
                    done_next   = 1'b1;
                end
                else if (fill_reg == CW'(QUEUE_DEPTH))
                begin
                    status_next = opq_pkg::STAT_FULL;
                    done_next   = 1'b1;
                end
                else
                begin
                    idx_next   = fill_reg;
                    state_next = (pos_reg == fill_reg) ? opq_pkg::ST_PLACE
                                                       : opq_pkg::ST_SHIFT_RD;
                end
            end

            opq_pkg::ST_SHIFT_RD:
            begin
                mem_raddr  = AW'(idx_reg - CW'(1));
                state_next = opq_pkg::ST_SHIFT_WR;
            end

            opq_pkg::ST_SHIFT_WR:
            begin
                // Move one entry down toward the tail
                mem_we   = 1'b1;
                idx_next = idx_reg - CW'(1);
                if (idx_reg - CW'(1) == pos_reg)
                    state_next = opq_pkg::ST_PLACE;
                else
                    state_next = opq_pkg::ST_SHIFT_RD;
            end

            opq_pkg::ST_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = item_reg;
                fill_next = fill_reg + CW'(1);
                if (pos_reg == '0)
                    head_next = item_reg.pid;
                done_next  = 1'b1;
                state_next = opq_pkg::ST_IDLE;
            end

            opq_pkg::ST_POP_RD:
            begin
                state_next = opq_pkg::ST_POP_WR;
            end

            opq_pkg::ST_POP_WR:
            begin
                // Move one entry up toward the head
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg - CW'(1));
                if (idx_reg == CW'(1))
                    head_next = mem_rdata.pid;
                if (idx_reg == fill_reg - CW'(1))
                begin
                    fill_next  = fill_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = opq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = opq_pkg::ST_POP_RD;
                end
            end

            default:
            begin
                state_next = opq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= opq_pkg::ST_IDLE;
            fill_reg  <= '0;
            kind_reg  <= '0;
            mode_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            kind_reg  <= kind_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        item_reg   <= item_next;
        pstate_reg <= pstate_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        posf_reg   <= posf_next;
        dup_reg    <= dup_next;
        head_reg   <= head_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
    end

    // Results; queue view comes straight from the post-step state
    assign busy        = (state_reg != opq_pkg::ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign popped_id   = popped_reg;
    assign found       = found_reg;
    assign is_empty    = (fill_reg == '0);
    assign head_id     = is_empty ? 16'd0 : head_reg;
    assign entry_total = 5'(fill_reg);

endmodule
`default_nettype wire

FILE: rtl/opq_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// opq_checker
// Port-level checks for the ordered process queue, bound to the top level.
// ---------------------------------------------------------------------------
module opq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic [15:0] popped_id,
    input wire logic [15:0] head_id,
    input wire logic        is_empty,
    input wire logic [4:0]  entry_total
);

    // A result appears only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted command either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command vanished");

    // An empty queue shows no head and no count
    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        is_empty |-> (head_id == 16'd0 && entry_total == 5'd0))
        else $error("empty queue shows head or count");

    // A pop that reports empty removes nothing
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == opq_pkg::STAT_EMPTY) |-> (popped_id == 16'd0 && is_empty))
        else $error("empty status with popped pid");

endmodule

bind ordered_process_queue opq_checker u_opq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .popped_id   (popped_id),
    .head_id     (head_id),
    .is_empty    (is_empty),
    .entry_total (entry_total)
);
`default_nettype wire
